// ===== design/urad_pkg.sv =====
// Shared widths and constants for the ultrasonic range averaging block.
package urad_pkg;

   // Field widths of the beats and the threshold register.
   localparam int WIDTH_W = 15;
   localparam int DIST_W  = 13;
   localparam int THR_W   = 12;

   // Pulse width to distance scaling: (width * 562) >> 11 gives cm in Q.4.
   localparam int SCALE_MUL   = 562;
   localparam int SCALE_W     = 10;
   localparam int SCALE_SHIFT = 11;
   localparam int PROD_W      = WIDTH_W + SCALE_W;
   localparam int CONV_W      = PROD_W - SCALE_SHIFT;

   // Accepted distance range and the preset value, in cm Q.4.
   localparam int MIN_Q4 = 32;
   localparam int MAX_Q4 = 6400;

   // Threshold register limits (exclusive) and reset value.
   localparam int THR_LOW_EXCL  = 80;
   localparam int THR_HIGH_EXCL = 3200;
   localparam int THR_RESET     = 480;

   // Default number of samples in the averaging window.
   localparam int SAMPLES_DEFAULT = 8;

endpackage

// ===== design/ultrasonic_range_average_detect.sv =====
// Ultrasonic echo range with moving average and obstacle detection, top level.
//
// Each request beat carries one echo pulse width in microseconds (zero means
// the echo timed out). Each accepted beat gives exactly one response beat with
// the distance in cm Q.4, the average over the last SAMPLES distances and an
// obstacle flag set when that average is at or below the threshold register.
// A timeout or a distance outside 2 cm to 400 cm repeats the last good one.
// Both channels use valid and stall; a beat moves at a clock edge with valid
// high and stall low. The threshold is written through csr_write_enable and
// csr_write_data; the user must write it only while no beat is in flight, as
// the block does not enforce this. Values outside 5 cm to 200 cm exclusive
// are ignored. One beat per cycle is sustained while no response stall holds
// it up: the pipeline is input register, conversion, ring read, running sum,
// and result register, with the ring read at entry and written one stage
// later so no slot is ever read and written together.
// A response stall is absorbed by the stages ahead of the result register, so
// requests are still taken until every stage is full. Synchronous reset
// empties the pipeline, presets the ring and sum to 400 cm, and sets the
// threshold to 30 cm; no clearing pass is needed.
module ultrasonic_range_average_detect
   import urad_pkg::*;
   #(
      parameter int SAMPLES = SAMPLES_DEFAULT
   )
   (
      input  logic               clock,
      input  logic               reset,
      input  logic               csr_write_enable,
      input  logic [THR_W-1:0]   csr_write_data,
      input  logic               req_valid,
      output logic               req_stall,
      input  logic [WIDTH_W-1:0] req_echo_width_us,
      output logic               rsp_valid,
      input  logic               rsp_stall,
      output logic [DIST_W-1:0]  rsp_distance_q4,
      output logic [DIST_W-1:0]  rsp_average_q4,
      output logic               rsp_obstacle
   );

   localparam int SUM_W = $clog2(SAMPLES * MAX_Q4 + 1);

   logic              conv_valid;
   logic              conv_stall;
   logic [DIST_W-1:0] conv_dist;
   logic              win_valid;
   logic              win_stall;
   logic [DIST_W-1:0] win_dist;
   logic [SUM_W-1:0]  win_sum;

   // Pulse width to distance.
   urad_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_width  (req_echo_width_us),
      .out_valid (conv_valid),
      .out_stall (conv_stall),
      .out_dist  (conv_dist)
   );

   // Sample ring and running sum.
   urad_window #(
      .SAMPLES (SAMPLES)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_valid),
      .in_stall  (conv_stall),
      .in_dist   (conv_dist),
      .out_valid (win_valid),
      .out_stall (win_stall),
      .out_dist  (win_dist),
      .out_sum   (win_sum)
   );

   // Average, threshold compare and response register.
   urad_average #(
      .SAMPLES (SAMPLES)
   ) u_average (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_valid         (win_valid),
      .in_stall         (win_stall),
      .in_dist          (win_dist),
      .in_sum           (win_sum),
      .out_valid        (rsp_valid),
      .out_stall        (rsp_stall),
      .out_distance     (rsp_distance_q4),
      .out_average      (rsp_average_q4),
      .out_obstacle     (rsp_obstacle)
   );

endmodule

// ===== design/urad_ram.sv =====
// Generic single write port RAM with one registered read port.
module urad_ram
   #(
      parameter int WIDTH = 13,
      parameter int DEPTH = 8
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic                     rd_en,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/urad_convert.sv =====
// Input register and pulse width to distance conversion with hold of the last good value.
module urad_convert
   import urad_pkg::*;
   (
      input  logic                clock,
      input  logic                reset,
      input  logic                in_valid,
      output logic                in_stall,
      input  logic [WIDTH_W-1:0]  in_width,
      output logic                out_valid,
      input  logic                out_stall,
      output logic [DIST_W-1:0]   out_dist
   );

   logic               valid_ff;
   logic               valid_in;
   logic [WIDTH_W-1:0] width_ff;
   logic [DIST_W-1:0]  last_valid_ff;
   logic [DIST_W-1:0]  last_valid_in;
   logic               take_out;
   logic               load;
   logic [PROD_W-1:0]  product;
   logic [CONV_W-1:0]  conv;
   logic               held;

   // Stage handshake.
   assign take_out  = valid_ff && !out_stall;
   assign load      = in_valid && (!valid_ff || !out_stall);
   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;

   // Scale the pulse width and check the result against the usable range.
   assign product = PROD_W'(width_ff) * PROD_W'(SCALE_MUL);
   assign conv    = product[PROD_W-1:SCALE_SHIFT];
   assign held    = (width_ff == '0) || (conv < CONV_W'(MIN_Q4)) ||
                    (conv > CONV_W'(MAX_Q4));
   assign out_dist = held ? last_valid_ff : conv[DIST_W-1:0];

   // The last good distance moves on only when a beat leaves this stage.
   always_comb begin
      last_valid_in = last_valid_ff;
      if (take_out && !held) begin
         last_valid_in = conv[DIST_W-1:0];
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take_out) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         last_valid_ff <= DIST_W'(MAX_Q4);
      end else begin
         valid_ff      <= valid_in;
         last_valid_ff <= last_valid_in;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         width_ff <= in_width;
      end
   end

endmodule

// ===== design/urad_window.sv =====
// Sample ring and running window sum over the last SAMPLES distances.
module urad_window
   import urad_pkg::*;
   #(
      parameter int SAMPLES = SAMPLES_DEFAULT
   )
   (
      input  logic                                clock,
      input  logic                                reset,
      input  logic                                in_valid,
      output logic                                in_stall,
      input  logic [DIST_W-1:0]                   in_dist,
      output logic                                out_valid,
      input  logic                                out_stall,
      output logic [DIST_W-1:0]                   out_dist,
      output logic [$clog2(SAMPLES*MAX_Q4+1)-1:0] out_sum
   );

   localparam int SUM_W  = $clog2(SAMPLES * MAX_Q4 + 1);
   localparam int ADDR_W = $clog2(SAMPLES);

   // Read side stage: distance, its slot and whether the slot holds a real sample.
   logic              b_valid_ff;
   logic              b_valid_in;
   logic [DIST_W-1:0] b_dist_ff;
   logic [ADDR_W-1:0] b_slot_ff;
   logic              b_old_ok_ff;

   // Sum side stage.
   logic              c_valid_ff;
   logic              c_valid_in;
   logic [DIST_W-1:0] c_dist_ff;
   logic [SUM_W-1:0]  c_sum_ff;

   // Ring pointer and running sum.
   logic [ADDR_W-1:0] slot_ff;
   logic [ADDR_W-1:0] slot_in;
   logic              wrapped_ff;
   logic              wrapped_in;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;

   logic              load_b;
   logic              load_c;
   logic              take_c;
   logic [DIST_W-1:0] ram_rd_data;
   logic [DIST_W-1:0] old_dist;

   // Handshake through both stages.
   assign take_c    = c_valid_ff && !out_stall;
   assign load_c    = b_valid_ff && (!c_valid_ff || !out_stall);
   assign load_b    = in_valid && (!b_valid_ff || load_c);
   assign in_stall  = b_valid_ff && !load_c;
   assign out_valid = c_valid_ff;
   assign out_dist  = c_dist_ff;
   assign out_sum   = c_sum_ff;

   // The ring is read when a beat enters and written when it leaves the read stage.
   urad_ram #(
      .WIDTH (DIST_W),
      .DEPTH (SAMPLES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (load_c),
      .wr_addr (b_slot_ff),
      .wr_data (b_dist_ff),
      .rd_en   (load_b),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // Slots not yet written on the first lap read as the preset distance.
   assign old_dist = b_old_ok_ff ? ram_rd_data : DIST_W'(MAX_Q4);

   always_comb begin
      slot_in    = slot_ff;
      wrapped_in = wrapped_ff;
      if (load_b) begin
         if (slot_ff == ADDR_W'(SAMPLES - 1)) begin
            slot_in    = '0;
            wrapped_in = 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
      sum_in = sum_ff;
      if (load_c) begin
         sum_in = sum_ff - SUM_W'(old_dist) + SUM_W'(b_dist_ff);
      end
      b_valid_in = b_valid_ff;
      if (load_b) begin
         b_valid_in = 1'b1;
      end else if (load_c) begin
         b_valid_in = 1'b0;
      end
      c_valid_in = c_valid_ff;
      if (load_c) begin
         c_valid_in = 1'b1;
      end else if (take_c) begin
         c_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         slot_ff    <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= SUM_W'(SAMPLES * MAX_Q4);
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         slot_ff    <= slot_in;
         wrapped_ff <= wrapped_in;
         sum_ff     <= sum_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load_b) begin
         b_dist_ff   <= in_dist;
         b_slot_ff   <= slot_ff;
         b_old_ok_ff <= wrapped_ff;
      end
      if (load_c) begin
         c_dist_ff <= b_dist_ff;
         c_sum_ff  <= sum_in;
      end
   end

endmodule

// ===== design/urad_average.sv =====
// Window average by reciprocal multiply, threshold register and result register.
module urad_average
   import urad_pkg::*;
   #(
      parameter int SAMPLES = SAMPLES_DEFAULT
   )
   (
      input  logic                                clock,
      input  logic                                reset,
      input  logic                                csr_write_enable,
      input  logic [THR_W-1:0]                    csr_write_data,
      input  logic                                in_valid,
      output logic                                in_stall,
      input  logic [DIST_W-1:0]                   in_dist,
      input  logic [$clog2(SAMPLES*MAX_Q4+1)-1:0] in_sum,
      output logic                                out_valid,
      input  logic                                out_stall,
      output logic [DIST_W-1:0]                   out_distance,
      output logic [DIST_W-1:0]                   out_average,
      output logic                                out_obstacle
   );

   // floor(sum / SAMPLES) == (sum * RECIP) >> SHIFT for every sum below 2**SUM_W.
   localparam int SUM_W   = $clog2(SAMPLES * MAX_Q4 + 1);
   localparam int SHIFT   = SUM_W + $clog2(SAMPLES);
   localparam logic [63:0] RECIP =
      ((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
   localparam int RECIP_W = $clog2(RECIP + 64'd1);
   localparam int MUL_W   = SUM_W + RECIP_W;

   logic              valid_ff;
   logic              valid_in;
   logic [DIST_W-1:0] distance_ff;
   logic [DIST_W-1:0] average_ff;
   logic              obstacle_ff;
   logic [THR_W-1:0]  threshold_ff;
   logic [THR_W-1:0]  threshold_in;
   logic              load;
   logic [MUL_W-1:0]  product;
   logic [DIST_W-1:0] average;

   assign load      = in_valid && (!valid_ff || !out_stall);
   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;

   // Average of the window.
   assign product = MUL_W'(in_sum) * MUL_W'(RECIP[RECIP_W-1:0]);
   assign average = DIST_W'(product >> SHIFT);

   // Threshold writes outside the allowed span are dropped.
   always_comb begin
      threshold_in = threshold_ff;
      if (csr_write_enable && (csr_write_data > THR_W'(THR_LOW_EXCL)) &&
          (csr_write_data < THR_W'(THR_HIGH_EXCL))) begin
         threshold_in = csr_write_data;
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!out_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         threshold_ff <= THR_W'(THR_RESET);
      end else begin
         valid_ff     <= valid_in;
         threshold_ff <= threshold_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load) begin
         distance_ff <= in_dist;
         average_ff  <= average;
         obstacle_ff <= (average <= DIST_W'(threshold_ff));
      end
   end

   assign out_distance = distance_ff;
   assign out_average  = average_ff;
   assign out_obstacle = obstacle_ff;

endmodule

// ===== verif/ultrasonic_range_average_detect_tb.sv =====
// Testbench for the ultrasonic range averaging block, checked against a predictor.
`timescale 1ns / 1ps

module ultrasonic_range_average_detect_tb;
   import urad_pkg::*;

   localparam int SAMPLES      = SAMPLES_DEFAULT;
   localparam int SETTLE_WAIT  = 8;
   localparam int MAX_WIDTH    = 32767;
   localparam int FIRST_GOOD_W = 117;
   localparam int LAST_GOOD_W  = 23326;

   // One response beat as the predictor expects it.
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [DIST_W-1:0] average;
      logic              obstacle;
   } range_beat_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic [THR_W-1:0]   csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic [WIDTH_W-1:0] req_echo_width_us;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [DIST_W-1:0]  rsp_distance_q4;
   logic [DIST_W-1:0]  rsp_average_q4;
   logic               rsp_obstacle;

   // Predictor state: threshold, last good distance, ring, slot and running sum.
   int unsigned threshold_q4;
   int unsigned last_good_q4;
   int unsigned ring_q4 [SAMPLES];
   int unsigned ring_slot;
   int unsigned window_total;

   range_beat_type expected_ranges [$];
   range_beat_type oldest_range;
   int             idle_pct;
   int             stall_pct;
   int             error_count;

   ultrasonic_range_average_detect #(
      .SAMPLES (SAMPLES)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_echo_width_us (req_echo_width_us),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_distance_q4   (rsp_distance_q4),
      .rsp_average_q4    (rsp_average_q4),
      .rsp_obstacle      (rsp_obstacle)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Convert one accepted echo width, update the ring and queue the expected beat.
   task automatic predict_range(input logic [WIDTH_W-1:0] width_us);
      int unsigned    converted;
      int unsigned    dist_q4;
      int unsigned    avg;
      range_beat_type beat;
      converted = (int'(width_us) * SCALE_MUL) >> SCALE_SHIFT;
      if (width_us == '0 || converted < MIN_Q4 || converted > MAX_Q4) begin
         dist_q4 = last_good_q4;
      end else begin
         dist_q4 = converted;
         last_good_q4 = converted;
      end
      window_total = window_total - ring_q4[ring_slot] + dist_q4;
      ring_q4[ring_slot] = dist_q4;
      ring_slot = (ring_slot == SAMPLES - 1) ? 0 : ring_slot + 1;
      avg = window_total / SAMPLES;
      beat.distance = DIST_W'(dist_q4);
      beat.average  = DIST_W'(avg);
      beat.obstacle = (avg <= threshold_q4);
      expected_ranges.push_back(beat);
   endtask

   // Send one request beat, with random idle cycles ahead of it.
   task automatic send_echo(input logic [WIDTH_W-1:0] width_us);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_echo_width_us <= WIDTH_W'($urandom());
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_echo_width_us <= width_us;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_range(width_us);
      @(negedge clock);
   endtask

   // Stop sending and wait until every expected beat has come back.
   task automatic drain_responses;
      req_valid <= 1'b0;
      while (expected_ranges.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   // Write the threshold register; the block must be idle.
   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (value > THR_LOW_EXCL && value < THR_HIGH_EXCL) begin
         threshold_q4 = value;
      end
      @(negedge clock);
   endtask

   // Timeouts, the conversion limits, wide pulses and the top input bit.
   task automatic test_held_distances;
      logic [WIDTH_W-1:0] boundary_widths [11] = '{
         0, 116, 117, 0, 23326, 23327, 30000, 30001, 32767, 16384, 1
      };
      idle_pct  = 0;
      stall_pct = 0;
      foreach (boundary_widths[i]) begin
         send_echo(boundary_widths[i]);
      end
   endtask

   // A full window of 30 cm brings the average exactly onto the reset threshold.
   task automatic test_obstacle_at_threshold;
      repeat (SAMPLES) send_echo(1750);
   endtask

   // Threshold writes at and beyond both limits, each followed by a window near it.
   task automatic test_threshold_register;
      logic [THR_W-1:0] limits [8] = '{80, 81, 3199, 3200, 0, 4095, 2100, 1000};
      int               width;
      idle_pct  = 31;
      stall_pct = 31;
      foreach (limits[i]) begin
         drain_responses();
         write_threshold(limits[i]);
         repeat (SAMPLES) begin
            width = (int'(limits[i]) * 2048) / SCALE_MUL + $urandom_range(8) - 4;
            if (width < 0) width = 0;
            if (width > MAX_WIDTH) width = MAX_WIDTH;
            send_echo(WIDTH_W'(width));
         end
      end
   endtask

   // Random traffic under one idling setting, with a new threshold first.
   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int count);
      int               level;
      int               pick;
      int               width;
      logic [THR_W-1:0] thr;
      drain_responses();
      if ($urandom_range(4) == 0) begin
         thr = THR_W'($urandom());
      end else begin
         thr = THR_W'($urandom_range(THR_HIGH_EXCL - 1, THR_LOW_EXCL + 1));
      end
      write_threshold(thr);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      level     = $urandom_range(LAST_GOOD_W, FIRST_GOOD_W);
      for (int i = 0; i < count; i++) begin
         // Halfway through, hold off until the block has emptied.
         if (i == count / 2) drain_responses();
         pick = $urandom_range(99);
         if (pick < 8) begin
            width = 0;
         end else if (pick < 20) begin
            width = $urandom_range(MAX_WIDTH);
         end else if (pick < 30) begin
            width = $urandom_range(150, 1);
         end else begin
            // Runs around a slowly moving level sweep the average across the threshold.
            if ($urandom_range(9) == 0) level = $urandom_range(LAST_GOOD_W, FIRST_GOOD_W);
            width = level + $urandom_range(600) - 300;
            if (width < 0) width = 0;
            if (width > MAX_WIDTH) width = MAX_WIDTH;
         end
         send_echo(WIDTH_W'(width));
      end
   endtask

   // Receiver stalls at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ranges.size() == 0) begin
            $error("response beat with none expected: distance_q4 %0d", rsp_distance_q4);
            error_count++;
         end else begin
            oldest_range = expected_ranges.pop_front();
            if (rsp_distance_q4 !== oldest_range.distance) begin
               $error("distance_q4 expected %0d actual %0d",
                      oldest_range.distance, rsp_distance_q4);
               error_count++;
            end
            if (rsp_average_q4 !== oldest_range.average) begin
               $error("average_q4 expected %0d actual %0d",
                      oldest_range.average, rsp_average_q4);
               error_count++;
            end
            if (rsp_obstacle !== oldest_range.obstacle) begin
               $error("obstacle expected %0d actual %0d",
                      oldest_range.obstacle, rsp_obstacle);
               error_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      req_valid         = 1'b0;
      req_echo_width_us = '0;
      rsp_stall         = 1'b0;
      idle_pct          = 0;
      stall_pct         = 0;
      error_count       = 0;
      threshold_q4      = THR_RESET;
      last_good_q4      = MAX_Q4;
      foreach (ring_q4[i]) ring_q4[i] = MAX_Q4;
      ring_slot         = 0;
      window_total      = SAMPLES * MAX_Q4;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_held_distances();
      test_obstacle_at_threshold();
      test_threshold_register();
      test_random_traffic(0, 0, 95);
      test_random_traffic(67, 0, 95);
      test_random_traffic(0, 67, 95);
      test_random_traffic(31, 31, 95);
      drain_responses();

      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
